@@ sv/mbu_pkg.sv @@
// ============================================================================
// mbu_pkg: shared types and constants of the masked bilinear upsampler
// Configuration register indexes, the configuration snapshot and a helper.
// ============================================================================
package mbu_pkg;

    // Fixed field widths
    localparam int POS_W     = 16;
    localparam int FACTOR_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Register indexes of the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVG_FACTOR  = 2'd0,
        CFG_SRC_MAX_ROW = 2'd1,
        CFG_SRC_MAX_COL = 2'd2
    } t_cfg_idx;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [FACTOR_W-1:0] avg_factor;
        logic [POS_W-1:0]    max_row;
        logic [POS_W-1:0]    max_col;
    } t_cfg;

    // A factor of zero behaves as a factor of one.
    function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] af);
        eff_factor = (af == '0) ? FACTOR_W'(1) : af;
    endfunction

endpackage

@@ sv/mbu_pdiv.sv @@
// ============================================================================
// mbu_pdiv: pipelined restoring divider
// One quotient bit per register stage, several lanes sharing one valid bit,
// with a side word that travels alongside. The dividend must be below
// divisor * 2**QW.
// ============================================================================
module mbu_pdiv #(
    parameter int DW    = 16,
    parameter int SW    = 8,
    parameter int QW    = 16,
    parameter int LANES = 1,
    parameter int PW    = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [LANES-1:0][DW-1:0]   i_dividend,
    input  logic [LANES-1:0][SW-1:0]   i_divisor,
    input  logic [PW-1:0]              i_side,
    output logic                       o_vld,
    output logic [LANES-1:0][QW-1:0]   o_quot,
    output logic [PW-1:0]              o_side
);

    localparam int CW = (DW > SW + QW) ? DW : SW + QW;

    logic                     r_vld  [QW];
    logic [LANES-1:0][DW-1:0] r_rem  [QW];
    logic [LANES-1:0][SW-1:0] r_dsr  [QW];
    logic [LANES-1:0][QW-1:0] r_quo  [QW];
    logic [PW-1:0]            r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;

        logic                     vld_in;
        logic [LANES-1:0][DW-1:0] rem_in;
        logic [LANES-1:0][SW-1:0] dsr_in;
        logic [LANES-1:0][QW-1:0] quo_in;
        logic [PW-1:0]            side_in;
        logic [LANES-1:0][DW-1:0] n_rem;
        logic [LANES-1:0][QW-1:0] n_quo;

        if (k == 0) begin : g_head
            assign vld_in  = i_vld;
            assign rem_in  = i_dividend;
            assign dsr_in  = i_divisor;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_body
            assign vld_in  = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign dsr_in  = r_dsr[k-1];
            assign quo_in  = r_quo[k-1];
            assign side_in = r_side[k-1];
        end

        // Trial subtraction of the shifted divisor decides one quotient bit.
        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            for (int l = 0; l < LANES; l++) begin
                if (CW'(rem_in[l]) >= (CW'(dsr_in[l]) << B)) begin
                    n_rem[l]    = DW'(CW'(rem_in[l]) - (CW'(dsr_in[l]) << B));
                    n_quo[l][B] = 1'b1;
                end
            end
        end

        // Stage valid bit.
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        // Stage payload.
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_dsr[k]  <= dsr_in;
                r_quo[k]  <= n_quo;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quot = r_quo[QW-1];
    assign o_side = r_side[QW-1];

endmodule

@@ sv/mbu_locate.sv @@
// ============================================================================
// mbu_locate: source cell clamp and weight numerators
// Clamps the top-left source index, forms the doubled weight numerator and
// prepares the operands of the weight quantizing division, per row and column.
// ============================================================================
module mbu_locate #(
    parameter int F  = 16,
    parameter int PW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  mbu_pkg::t_cfg         i_cfg,
    input  logic [1:0][15:0]      i_quot,
    input  logic [1:0][15:0]      i_pos,
    input  logic [PW-1:0]         i_side,
    output logic                  o_vld,
    output logic [1:0][15:0]      o_idx,
    output logic [1:0][F+8:0]     o_dividend,
    output logic [1:0][8:0]       o_divisor,
    output logic [1:0]            o_zero,
    output logic [1:0]            o_full,
    output logic [1:0]            o_far,
    output logic [PW-1:0]         o_side
);

    logic [7:0]  a;
    logic [1:0][15:0] top;

    logic                   r_b1_vld, r_b2_vld, r_b3_vld;
    logic [1:0][15:0]       r_b1_idx, r_b1_pos, r_b2_idx, r_b3_idx;
    logic [PW-1:0]          r_b1_side, r_b2_side, r_b3_side;
    logic signed [19:0]     r_b2_num [2];
    logic [1:0][F+8:0]      r_b3_dividend;
    logic [1:0][8:0]        r_b3_divisor;
    logic [1:0]             r_b3_zero, r_b3_full, r_b3_far;

    logic [1:0][15:0]       n_b1_idx;
    logic signed [19:0]     n_b2_num [2];
    logic [1:0][23:0]       prod;
    logic [1:0][F+8:0]      n_b3_dividend;
    logic [1:0]             n_b3_zero, n_b3_full, n_b3_far;

    assign a = mbu_pkg::eff_factor(i_cfg.avg_factor);

    // Largest allowed top index, so the lower and right neighbors exist.
    assign top[0] = (i_cfg.max_row == '0) ? 16'd0 : i_cfg.max_row - 16'd1;
    assign top[1] = (i_cfg.max_col == '0) ? 16'd0 : i_cfg.max_col - 16'd1;

    // First stage: clamp the index.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_b1_idx[l] = (i_quot[l] > top[l]) ? top[l] : i_quot[l];
        end
    end

    // Second stage: doubled numerator 2*pos + 1 - 2*idx*A - A.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            prod[l]     = 24'(r_b1_idx[l]) * 24'(a);
            n_b2_num[l] = $signed({3'b000, r_b1_pos[l], 1'b1})
                        - $signed({3'b000, prod[l][15:0], 1'b0})
                        - $signed({12'd0, a});
        end
    end

    // Third stage: saturation flags and the quantizing division operands.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_b3_zero[l] = (r_b2_num[l] <= 20'sd0);
            n_b3_full[l] = (r_b2_num[l] >= $signed({11'd0, a, 1'b0}));
            n_b3_far[l]  = (r_b2_num[l] > $signed({12'd0, a}));
            if (n_b3_zero[l] || n_b3_full[l]) begin
                n_b3_dividend[l] = '0;
            end else begin
                n_b3_dividend[l] = {r_b2_num[l][8:0], {F{1'b0}}} + (F+9)'(a);
            end
        end
    end

    // Valid bits of the three stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
        end else if (i_en) begin
            r_b1_vld <= i_vld;
            r_b2_vld <= r_b1_vld;
            r_b3_vld <= r_b2_vld;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b1_idx      <= n_b1_idx;
            r_b1_pos      <= i_pos;
            r_b1_side     <= i_side;
            r_b2_idx      <= r_b1_idx;
            r_b2_num      <= n_b2_num;
            r_b2_side     <= r_b1_side;
            r_b3_idx      <= r_b2_idx;
            r_b3_dividend <= n_b3_dividend;
            r_b3_divisor  <= {{a, 1'b0}, {a, 1'b0}};
            r_b3_zero     <= n_b3_zero;
            r_b3_full     <= n_b3_full;
            r_b3_far      <= n_b3_far;
            r_b3_side     <= r_b2_side;
        end
    end

    assign o_vld      = r_b3_vld;
    assign o_idx      = r_b3_idx;
    assign o_dividend = r_b3_dividend;
    assign o_divisor  = r_b3_divisor;
    assign o_zero     = r_b3_zero;
    assign o_full     = r_b3_full;
    assign o_far      = r_b3_far;
    assign o_side     = r_b3_side;

endmodule

@@ sv/mbu_blend.sv @@
// ============================================================================
// mbu_blend: corner weights and masked weighted sums
// Forms the four corner weights, the weighted sum of valid values and the
// weight total, and prepares the rounding division.
// ============================================================================
module mbu_blend #(
    parameter int VB = 16,
    parameter int F  = 16,
    parameter int PW = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic [1:0][F-1:0]     i_quot,
    input  logic [1:0]            i_zero,
    input  logic [1:0]            i_full,
    input  logic [3:0][VB-1:0]    i_value,
    input  logic [3:0]            i_mask,
    input  logic [PW-1:0]         i_side,
    output logic                  o_vld,
    output logic [F+VB+2:0]       o_dividend,
    output logic [F+2:0]          o_divisor,
    output logic                  o_neg,
    output logic                  o_nz,
    output logic [PW-1:0]         o_side
);

    localparam logic [F:0]      ONE  = {1'b1, {F{1'b0}}};
    localparam logic [2*F+1:0]  HALF = (2*F+2)'(1) << (F - 1);

    // Valid bits of the five stages.
    logic [4:0] r_vld;

    logic [1:0][F:0]         r_c1_wt, r_c1_owt;
    logic [3:0][F:0]         r_c2_w;
    logic signed [F+VB+1:0]  r_c3_t [4];
    logic [3:0][F:0]         r_c3_dw;
    logic signed [F+VB+3:0]  r_c4_num;
    logic [F+2:0]            r_c4_den;
    logic [F+VB+2:0]         r_c5_dividend;
    logic [F+2:0]            r_c5_divisor;
    logic                    r_c5_neg, r_c5_nz;
    logic [3:0][VB-1:0]      r_c1_val, r_c2_val;
    logic [3:0]              r_c1_mask, r_c2_mask;
    logic [PW-1:0]           r_c1_side, r_c2_side, r_c3_side, r_c4_side, r_c5_side;

    logic [1:0][F:0]         n_c1_wt, n_c1_owt;
    logic [3:0][2*F+1:0]     prod;
    logic [3:0][F:0]         n_c2_w;
    logic signed [F+VB+1:0]  n_c3_t [4];
    logic [3:0][F:0]         n_c3_dw;
    logic [F+VB+2:0]         mag;

    // First stage: quantized weights and their complements.
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (i_full[l]) begin
                n_c1_wt[l] = ONE;
            end else if (i_zero[l]) begin
                n_c1_wt[l] = '0;
            end else begin
                n_c1_wt[l] = {1'b0, i_quot[l]};
            end
            n_c1_owt[l] = ONE - n_c1_wt[l];
        end
    end

    // Second stage: corner weights, rounded half up back to the weight format.
    always_comb begin
        prod[0] = (2*F+2)'(r_c1_owt[0]) * (2*F+2)'(r_c1_owt[1]);
        prod[1] = (2*F+2)'(r_c1_owt[0]) * (2*F+2)'(r_c1_wt[1]);
        prod[2] = (2*F+2)'(r_c1_wt[0])  * (2*F+2)'(r_c1_owt[1]);
        prod[3] = (2*F+2)'(r_c1_wt[0])  * (2*F+2)'(r_c1_wt[1]);
        for (int i = 0; i < 4; i++) begin
            n_c2_w[i] = (F+1)'((prod[i] + HALF) >> F);
        end
    end

    // Third stage: weighted values of the valid corners.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (r_c2_mask[i]) begin
                n_c3_t[i]  = $signed({1'b0, r_c2_w[i]}) * $signed(r_c2_val[i]);
                n_c3_dw[i] = r_c2_w[i];
            end else begin
                n_c3_t[i]  = '0;
                n_c3_dw[i] = '0;
            end
        end
    end

    // Fifth stage operand: magnitude of the sum.
    assign mag = r_c4_num[F+VB+3] ? (F+VB+3)'(-r_c4_num) : (F+VB+3)'(r_c4_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_vld};
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c1_wt       <= n_c1_wt;
            r_c1_owt      <= n_c1_owt;
            r_c1_val      <= i_value;
            r_c1_mask     <= i_mask;
            r_c1_side     <= i_side;
            r_c2_w        <= n_c2_w;
            r_c2_val      <= r_c1_val;
            r_c2_mask     <= r_c1_mask;
            r_c2_side     <= r_c1_side;
            r_c3_t        <= n_c3_t;
            r_c3_dw       <= n_c3_dw;
            r_c3_side     <= r_c2_side;
            r_c4_num      <= (F+VB+4)'(r_c3_t[0]) + (F+VB+4)'(r_c3_t[1])
                           + (F+VB+4)'(r_c3_t[2]) + (F+VB+4)'(r_c3_t[3]);
            r_c4_den      <= (F+3)'(r_c3_dw[0]) + (F+3)'(r_c3_dw[1])
                           + (F+3)'(r_c3_dw[2]) + (F+3)'(r_c3_dw[3]);
            r_c4_side     <= r_c3_side;
            r_c5_dividend <= mag + (F+VB+3)'(r_c4_den >> 1);
            r_c5_divisor  <= (r_c4_den == '0) ? (F+3)'(1) : r_c4_den;
            r_c5_neg      <= r_c4_num[F+VB+3];
            r_c5_nz       <= (r_c4_den != '0);
            r_c5_side     <= r_c4_side;
        end
    end

    assign o_vld      = r_vld[4];
    assign o_dividend = r_c5_dividend;
    assign o_divisor  = r_c5_divisor;
    assign o_neg      = r_c5_neg;
    assign o_nz       = r_c5_nz;
    assign o_side     = r_c5_side;

endmodule

@@ sv/masked_bilinear_upsampler_unit.sv @@
// Throughput: one word per cycle; a stall holds the whole pipeline, an output skid
// register keeps the input side open while one finished word waits.
// Reset: synchronous, active low; clears all valid bits and loads the register defaults.
// ============================================================================
// masked_bilinear_upsampler_unit: masked bilinear upsampler top level
// Computes a normalized bilinear average over the valid source neighbors of
// each target pixel, together with the clamped source cell and nearest corner.
// ============================================================================
module masked_bilinear_upsampler_unit #(
    parameter int VALUE_BITS       = 16,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mbu_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mbu_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    // Input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // target_row, target_col, value_tl, value_tr, value_bl, value_br, zero pad
    input  logic [((32+4*VALUE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // valid_mask
    input  logic [3:0]                           s_axis_tuser,
    // Output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // result_value, nearest_corner, source_row, source_col, zero pad
    output logic [((34+VALUE_BITS+7)/8)*8-1:0]   m_axis_tdata,
    // result_valid
    output logic [0:0]                           m_axis_tuser
);

    localparam int VB    = VALUE_BITS;
    localparam int F     = WEIGHT_FRAC_BITS;
    localparam int OUT_W = ((34 + VB + 7) / 8) * 8;
    localparam int S1_W  = 32 + 4 * VB + 4;
    localparam int S2_W  = 4 * VB + 4;
    localparam int S3_W  = 32 + 6 + 4 * VB + 4;
    localparam int S4_W  = 34;
    localparam int S5_W  = 36;

    localparam logic [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};

    logic en;
    mbu_pkg::t_cfg r_cfg;

    logic [7:0]        a, half;
    logic [1:0][15:0]  pos_in, div1_num;
    logic [3:0][VB-1:0] val_in;

    logic              d1_vld;
    logic [1:0][15:0]  d1_quot;
    logic [S1_W-1:0]   d1_side;

    logic              lc_vld;
    logic [1:0][15:0]  lc_idx;
    logic [1:0][F+8:0] lc_dividend;
    logic [1:0][8:0]   lc_divisor;
    logic [1:0]        lc_zero, lc_full, lc_far;
    logic [S2_W-1:0]   lc_side;

    logic              d2_vld;
    logic [1:0][F-1:0] d2_quot;
    logic [S3_W-1:0]   d2_side;

    logic              bl_vld, bl_neg, bl_nz;
    logic [F+VB+2:0]   bl_dividend;
    logic [F+2:0]      bl_divisor;
    logic [S4_W-1:0]   bl_side;

    logic              d3_vld;
    logic [0:0][VB-1:0] d3_quot;
    logic [S5_W-1:0]   d3_side;

    logic [VB-1:0]     res;
    logic [OUT_W-1:0]  fin_data;
    logic              take;

    logic              r_out_vld, r_skid_vld, n_out_vld, n_skid_vld;
    logic [OUT_W-1:0]  r_out_data, r_skid_data, n_out_data, n_skid_data;
    logic              r_out_user, r_skid_user, n_out_user, n_skid_user;

    // Configuration registers, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.avg_factor <= 8'd8;
            r_cfg.max_row    <= 16'd1023;
            r_cfg.max_col    <= 16'd1023;
        end else if (i_cfg_valid) begin
            unique case (mbu_pkg::t_cfg_idx'(i_cfg_index))
                mbu_pkg::CFG_AVG_FACTOR:  r_cfg.avg_factor <= i_cfg_data[7:0];
                mbu_pkg::CFG_SRC_MAX_ROW: r_cfg.max_row    <= i_cfg_data;
                mbu_pkg::CFG_SRC_MAX_COL: r_cfg.max_col    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the skid register is empty.
    assign en            = !r_skid_vld;
    assign s_axis_tready = en;

    // Input unpacking and the index division operand: pos - A/2, floored at zero.
    assign a    = mbu_pkg::eff_factor(r_cfg.avg_factor);
    assign half = a >> 1;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            pos_in[l] = s_axis_tdata[16*l +: 16];
            div1_num[l] = (pos_in[l] < 16'(half)) ? 16'd0 : pos_in[l] - 16'(half);
        end
        for (int i = 0; i < 4; i++) begin
            val_in[i] = s_axis_tdata[32 + VB*i +: VB];
        end
    end

    // Source index division by the averaging factor.
    mbu_pdiv #(
        .DW(16), .SW(8), .QW(16), .LANES(2), .PW(S1_W)
    ) u_div_idx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (s_axis_tvalid),
        .i_dividend (div1_num),
        .i_divisor  ({a, a}),
        .i_side     ({s_axis_tuser, val_in, pos_in}),
        .o_vld      (d1_vld),
        .o_quot     (d1_quot),
        .o_side     (d1_side)
    );

    mbu_locate #(
        .F(F), .PW(S2_W)
    ) u_locate (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (d1_vld),
        .i_cfg      (r_cfg),
        .i_quot     (d1_quot),
        .i_pos      (d1_side[31:0]),
        .i_side     (d1_side[S1_W-1:32]),
        .o_vld      (lc_vld),
        .o_idx      (lc_idx),
        .o_dividend (lc_dividend),
        .o_divisor  (lc_divisor),
        .o_zero     (lc_zero),
        .o_full     (lc_full),
        .o_far      (lc_far),
        .o_side     (lc_side)
    );

    // Weight quantizing division, rows and columns side by side.
    mbu_pdiv #(
        .DW(F + 9), .SW(9), .QW(F), .LANES(2), .PW(S3_W)
    ) u_div_wt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (lc_vld),
        .i_dividend (lc_dividend),
        .i_divisor  (lc_divisor),
        .i_side     ({lc_side, lc_full, lc_zero, lc_far[0], lc_far[1], lc_idx}),
        .o_vld      (d2_vld),
        .o_quot     (d2_quot),
        .o_side     (d2_side)
    );

    mbu_blend #(
        .VB(VB), .F(F), .PW(S4_W)
    ) u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (d2_vld),
        .i_quot     (d2_quot),
        .i_zero     (d2_side[35:34]),
        .i_full     (d2_side[37:36]),
        .i_value    (d2_side[38 +: 4*VB]),
        .i_mask     (d2_side[S3_W-1 -: 4]),
        .i_side     (d2_side[33:0]),
        .o_vld      (bl_vld),
        .o_dividend (bl_dividend),
        .o_divisor  (bl_divisor),
        .o_neg      (bl_neg),
        .o_nz       (bl_nz),
        .o_side     (bl_side)
    );

    // Rounding division of the weighted sum by the weight total.
    mbu_pdiv #(
        .DW(F + VB + 3), .SW(F + 3), .QW(VB), .LANES(1), .PW(S5_W)
    ) u_div_avg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_vld      (bl_vld),
        .i_dividend (bl_dividend),
        .i_divisor  (bl_divisor),
        .i_side     ({bl_nz, bl_neg, bl_side}),
        .o_vld      (d3_vld),
        .o_quot     (d3_quot),
        .o_side     (d3_side)
    );

    // Sign and saturation of the rounded quotient.
    always_comb begin
        if (d3_side[34]) begin
            res = (d3_quot[0] > VMIN) ? VMIN : VB'(-d3_quot[0]);
        end else begin
            res = (d3_quot[0] > VMAX) ? VMAX : d3_quot[0];
        end
    end

    // Corner: bit 1 from the row numerator, bit 0 from the column numerator.
    assign fin_data = OUT_W'({d3_side[31:16], d3_side[15:0], d3_side[33:32], res});

    // Output register with one skid entry behind it.
    always_comb begin
        take        = r_out_vld && m_axis_tready;
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_skid_vld  = r_skid_vld;
        n_skid_data = r_skid_data;
        n_skid_user = r_skid_user;
        if (r_skid_vld) begin
            if (!r_out_vld || take) begin
                n_out_vld  = 1'b1;
                n_out_data = r_skid_data;
                n_out_user = r_skid_user;
                n_skid_vld = 1'b0;
            end
        end else if (d3_vld) begin
            if (!r_out_vld || take) begin
                n_out_vld  = 1'b1;
                n_out_data = fin_data;
                n_out_user = d3_side[35];
            end else begin
                n_skid_vld  = 1'b1;
                n_skid_data = fin_data;
                n_skid_user = d3_side[35];
            end
        end else if (take) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_out_user  <= n_out_user;
        r_skid_data <= n_skid_data;
        r_skid_user <= n_skid_user;
    end

    assign m_axis_tvalid   = r_out_vld;
    assign m_axis_tdata    = r_out_data;
    assign m_axis_tuser[0] = r_out_user;

endmodule
